FILE: src/svtd_pkg.sv
// ----------------------------------------------------------------------------
// svtd_pkg
// Shared constants, types and helpers for the sensor value type decoder.
// ----------------------------------------------------------------------------
package svtd_pkg;

  // fraction bits of the decoded value (valid range 16..24)
  localparam int FRAC_BITS = 16;

  localparam int TYPE_W  = 32;
  localparam int SIZE_W  = 6;
  localparam int WORD_W  = 32;
  localparam int VALUE_W = 64;

  // in_tdata: data_size, data_word, padded to whole bytes
  localparam int IN_DATA_W  = ((SIZE_W + WORD_W + 7) / 8) * 8;
  localparam int IN_PAD_W   = IN_DATA_W - SIZE_W - WORD_W;
  localparam int OUT_USER_W = 2;

  // type codes, first character in the top byte
  localparam logic [TYPE_W-1:0] TC_FLT  = "flt ";
  localparam logic [TYPE_W-1:0] TC_UI8  = "ui8 ";
  localparam logic [TYPE_W-1:0] TC_UI16 = "ui16";
  localparam logic [TYPE_W-1:0] TC_UI32 = "ui32";
  localparam logic [TYPE_W-1:0] TC_SI8  = "si8 ";
  localparam logic [TYPE_W-1:0] TC_SI16 = "si16";
  localparam logic [7:0]        CH_P    = "p";
  localparam logic [7:0]        CH_F    = "f";
  localparam logic [7:0]        CH_S    = "s";

  localparam logic [7:0] FLT_EXP_SPECIAL = 8'hff;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               saturated;
  } svtd_fcvt_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               decoded;
    logic               saturated;
  } svtd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } svtd_hex_t;

  function automatic svtd_hex_t hex_digit(input logic [7:0] ch);
    svtd_hex_t h;
    h.ok    = 1'b1;
    h.digit = 4'd0;
    if (ch >= "0" && ch <= "9") begin
      h.digit = 4'(ch - "0");
    end else if (ch >= "a" && ch <= "f") begin
      h.digit = 4'(ch - "a" + 8'd10);
    end else if (ch >= "A" && ch <= "F") begin
      h.digit = 4'(ch - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: src/svtd_float_cvt.sv
// ----------------------------------------------------------------------------
// svtd_float_cvt
// IEEE single to signed fixed point, truncating toward zero, saturating.
// ----------------------------------------------------------------------------
module svtd_float_cvt
  import svtd_pkg::*;
(
  input  logic [31:0] float_bits,
  output svtd_fcvt_t  cvt
);

  localparam logic [VALUE_W-1:0] MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] MAX_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [9:0]  SH_OFS  = 10'(150 - FRAC_BITS);
  localparam logic signed [9:0]  SH_MAX  = 10'sd39;

  logic               neg;
  logic [7:0]         expo;
  logic [22:0]        frac;
  logic [23:0]        sig;
  logic signed [9:0]  sh;
  logic [9:0]         nsh;
  logic [VALUE_W-1:0] sig_ext;
  logic [VALUE_W-1:0] mag;
  logic               exact_min;

  always_comb begin
    neg       = float_bits[31];
    expo      = float_bits[30:23];
    frac      = float_bits[22:0];
    sig       = {1'b1, frac};
    sh        = $signed({2'b00, expo}) - SH_OFS;
    nsh       = 10'(-sh);
    sig_ext   = {{(VALUE_W-24){1'b0}}, sig};
    exact_min = neg && (sh == SH_MAX + 10'sd1) && (frac == '0);
    if (sh < 0) begin
      mag = sig_ext >> nsh;
    end else begin
      mag = sig_ext << sh[5:0];
    end

    cvt.value     = '0;
    cvt.saturated = 1'b0;
    if (expo == FLT_EXP_SPECIAL) begin
      cvt.saturated = 1'b1;
      if (frac == '0) begin
        cvt.value = neg ? MAX_NEG : MAX_POS;
      end
    end else if (expo == '0) begin
      cvt.value = '0;  // denormals are far below one LSB
    end else if (sh > SH_MAX) begin
      if (exact_min) begin
        cvt.value = MAX_NEG;
      end else begin
        cvt.saturated = 1'b1;
        cvt.value     = neg ? MAX_NEG : MAX_POS;
      end
    end else begin
      cvt.value = neg ? (VALUE_W'(0) - mag) : mag;
    end
  end

endmodule

FILE: src/svtd_decode.sv
// ----------------------------------------------------------------------------
// svtd_decode
// Type code match and value formation for one registered input item.
// ----------------------------------------------------------------------------
module svtd_decode
  import svtd_pkg::*;
(
  input  logic [TYPE_W-1:0] type_code,
  input  logic [SIZE_W-1:0] data_size,
  input  logic [WORD_W-1:0] data_word,
  output svtd_result_t      result
);

  logic [7:0]         b0, b1, b2, b3;
  logic [15:0]        hi16;
  logic [7:0]         c0, c1;
  svtd_hex_t          hx;
  svtd_fcvt_t         fcvt;
  logic [VALUE_W-1:0] raw_fx;
  logic [4:0]         fx_shift;

  assign b0   = data_word[31:24];
  assign b1   = data_word[23:16];
  assign b2   = data_word[15:8];
  assign b3   = data_word[7:0];
  assign hi16 = {b0, b1};
  assign c0   = type_code[31:24];
  assign c1   = type_code[23:16];

  // float bytes arrive little-endian
  svtd_float_cvt u_fcvt (
    .float_bits ({b3, b2, b1, b0}),
    .cvt        (fcvt)
  );

  always_comb begin
    hx       = hex_digit(type_code[7:0]);
    raw_fx   = (c0 == CH_S) ? VALUE_W'($signed(hi16)) : VALUE_W'(hi16);
    fx_shift = 5'(FRAC_BITS - int'(hx.digit));

    result.value     = '0;
    result.decoded   = 1'b0;
    result.saturated = 1'b0;
    if (type_code == TC_FLT && data_size >= 6'd4) begin
      result.value     = fcvt.value;
      result.saturated = fcvt.saturated;
      result.decoded   = 1'b1;
    end else if (type_code == TC_UI8 && data_size >= 6'd1) begin
      result.value   = VALUE_W'(b0) << FRAC_BITS;
      result.decoded = 1'b1;
    end else if (type_code == TC_UI16 && data_size >= 6'd2) begin
      result.value   = VALUE_W'(hi16) << FRAC_BITS;
      result.decoded = 1'b1;
    end else if (type_code == TC_UI32 && data_size >= 6'd4) begin
      result.value   = VALUE_W'(data_word) << FRAC_BITS;
      result.decoded = 1'b1;
    end else if (type_code == TC_SI8 && data_size >= 6'd1) begin
      result.value   = VALUE_W'($signed(b0)) << FRAC_BITS;
      result.decoded = 1'b1;
    end else if (type_code == TC_SI16 && data_size >= 6'd2) begin
      result.value   = VALUE_W'($signed(hi16)) << FRAC_BITS;
      result.decoded = 1'b1;
    end else if (c1 == CH_P && (c0 == CH_F || c0 == CH_S) && data_size >= 6'd2
                 && hx.ok) begin
      // third character is a don't-care
      result.value   = raw_fx << fx_shift;
      result.decoded = 1'b1;
    end
  end

endmodule

FILE: src/sensor_value_type_decoder.sv
// ----------------------------------------------------------------------------
// sensor_value_type_decoder
// Decodes a sensor key (type code, size, first data bytes) to 64-bit fixed
// point with FRAC_BITS fraction bits.
//
// Input stream: in_tuser carries the four-character type code, in_tdata the
// data size and the first four data bytes. Output stream: out_tdata carries
// the signed value, out_tuser the decoded and saturated flags.
// Each transfer is captured in an input register, decoded by one pass of
// combinational logic and loaded into the output register, which drives
// out_tvalid. Throughput is one item per cycle while the receiver accepts
// each result; a receiver stall holds items in the two registers.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more item; in_tready drops only when
// both are full. Reset (rst_n low, synchronous) empties both registers.
// ----------------------------------------------------------------------------
module sensor_value_type_decoder
  import svtd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // data_size[5:0], data_word[37:6], pad
  input  logic [TYPE_W-1:0]     in_tuser,   // type_code[31:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VALUE_W-1:0]    out_tdata,  // value[63:0]
  output logic [OUT_USER_W-1:0] out_tuser   // decoded[0], saturated[1]
);

  logic               s1_vld_r, s1_vld_nxt;
  logic [TYPE_W-1:0]  s1_type_r;
  logic [SIZE_W-1:0]  s1_size_r;
  logic [WORD_W-1:0]  s1_word_r;
  logic               out_vld_r, out_vld_nxt;
  svtd_result_t       out_res_r;
  svtd_result_t       dec_res;
  logic               in_xfer;
  logic               s2_load;

  assign s2_load   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s2_load;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (s2_load) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s2_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_type_r <= in_tuser;
      s1_size_r <= in_tdata[SIZE_W-1:0];
      s1_word_r <= in_tdata[SIZE_W +: WORD_W];
    end
    if (s2_load) begin
      out_res_r <= dec_res;
    end
  end

  svtd_decode u_decode (
    .type_code (s1_type_r),
    .data_size (s1_size_r),
    .data_word (s1_word_r),
    .result    (dec_res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = {out_res_r.saturated, out_res_r.decoded};

  a_sat_needs_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_res_r.saturated || out_res_r.decoded))
    else $error("saturated result without decoded");

  a_undecoded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.decoded) |-> (out_res_r.value == '0))
    else $error("undecoded result carries a nonzero value");

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && out_vld_r && !out_tready))
    else $error("input stalled while a register is free");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s2_load) |=> (s1_vld_r && $stable(s1_word_r)))
    else $error("input register lost an item under stall");

endmodule
